// ===== sv/vot_pkg.sv =====
// ----------------------------------------------------------------------------
// vot_pkg
// Shared types and constants of the voxel occupancy test-and-mark block.
// ----------------------------------------------------------------------------
package vot_pkg;

  localparam int POS_W    = 24;
  localparam int INV_W    = 16;
  localparam int DIFF_W   = POS_W + 1;
  localparam int PROD_W   = DIFF_W + INV_W + 1;
  localparam int FRAC_W   = 20;
  localparam int CELL_W   = PROD_W - FRAC_W;
  localparam int WORD_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_Z = 3'd5;

  localparam logic [INV_W-1:0] INV_CELL_RESET = 16'd4096;

  localparam logic REQ_MARK  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic              occupied;
    logic [WORD_W-1:0] z_mask;
  } out_t;

endpackage

// ===== sv/voxel_occupancy_test_and_mark.sv =====
// ----------------------------------------------------------------------------
// voxel_occupancy_test_and_mark
// Maps a point into a bit grid and tests and marks up to 2x2 z columns.
// ----------------------------------------------------------------------------
// Mark request: the three axes pass through one subtract/multiply/clamp unit,
//   then one read and one check/write of the single-port column memory per
//   column visited (1 to 4).
// Clear request: the map is swept to zero, one memory word per cycle.
// Requests are taken one at a time; a held result holds off input.
// Reset: synchronous; the map is then swept to zero.
module voxel_occupancy_test_and_mark #(
  parameter int GRID_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vot_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vot_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [vot_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [vot_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  localparam int CELLS = GRID_BITS * GRID_BITS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(GRID_BITS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
  localparam logic signed [vot_pkg::CELL_W-1:0] CELL_MAX =
    vot_pkg::CELL_W'(GRID_BITS - 1);
  localparam logic signed [vot_pkg::PROD_W-1:0] CEIL_BIAS =
    vot_pkg::PROD_W'((1 << vot_pkg::FRAC_W) - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SUB, S_MUL, S_CLAMP, S_RD, S_CHK, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    AX_X, AX_Y, AX_Z
  } axis_t;

  function automatic logic [CW-1:0] clamp_cell(
    input logic signed [vot_pkg::CELL_W-1:0] c
  );
    logic [CW-1:0] r;
    if (c < 0) begin
      r = '0;
    end else if (c > CELL_MAX) begin
      r = CW'(GRID_BITS - 1);
    end else begin
      r = c[CW-1:0];
    end
    return r;
  endfunction

  logic signed [vot_pkg::POS_W-1:0] origin_x_r, origin_y_r, origin_z_r;
  logic [vot_pkg::INV_W-1:0]        inv_x_r, inv_y_r, inv_z_r;

  state_t                            state_r, state_nxt;
  axis_t                             ax_r, ax_nxt;
  vot_pkg::in_t                      item_r, item_nxt;
  logic signed [vot_pkg::DIFF_W-1:0] d_r, d_nxt;
  logic signed [vot_pkg::PROD_W-1:0] p_r, p_nxt;
  logic [CW-1:0]                     x0_r, x0_nxt, x1_r, x1_nxt;
  logic [CW-1:0]                     y0_r, y0_nxt, y1_r, y1_nxt;
  logic [CW-1:0]                     x_r, x_nxt, y_r, y_nxt;
  logic [vot_pkg::WORD_W-1:0]        mask_r, mask_nxt;
  logic [AW-1:0]                     sweep_r, sweep_nxt;
  logic                              clr_rep_r, clr_rep_nxt;
  logic                              hit_r, hit_nxt;
  logic                              out_valid_r, out_valid_nxt;
  vot_pkg::out_t                     out_data_r, out_data_nxt;

  logic [vot_pkg::WORD_W-1:0]        mem [CELLS];
  logic [vot_pkg::WORD_W-1:0]        rd_data_r;
  logic                              mem_we;
  logic [AW-1:0]                     mem_addr;
  logic [vot_pkg::WORD_W-1:0]        mem_wdata;

  logic signed [vot_pkg::POS_W-1:0]  pos_sel, org_sel;
  logic [vot_pkg::INV_W-1:0]         inv_sel;
  logic signed [vot_pkg::PROD_W-1:0] p_ceil;
  logic [CW-1:0]                     lo_cell, hi_cell;
  logic [AW-1:0]                     cell_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      inv_x_r    <= vot_pkg::INV_CELL_RESET;
      inv_y_r    <= vot_pkg::INV_CELL_RESET;
      inv_z_r    <= vot_pkg::INV_CELL_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        vot_pkg::CFG_ORIGIN_X:   origin_x_r <= cfg_wdata;
        vot_pkg::CFG_ORIGIN_Y:   origin_y_r <= cfg_wdata;
        vot_pkg::CFG_ORIGIN_Z:   origin_z_r <= cfg_wdata;
        vot_pkg::CFG_INV_CELL_X: inv_x_r <= cfg_wdata[vot_pkg::INV_W-1:0];
        vot_pkg::CFG_INV_CELL_Y: inv_y_r <= cfg_wdata[vot_pkg::INV_W-1:0];
        vot_pkg::CFG_INV_CELL_Z: inv_z_r <= cfg_wdata[vot_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ax_r)
      AX_X: begin
        pos_sel = item_r.pos_x;
        org_sel = origin_x_r;
        inv_sel = inv_x_r;
      end
      AX_Y: begin
        pos_sel = item_r.pos_y;
        org_sel = origin_y_r;
        inv_sel = inv_y_r;
      end
      default: begin
        pos_sel = item_r.pos_z;
        org_sel = origin_z_r;
        inv_sel = inv_z_r;
      end
    endcase
  end

  assign p_ceil    = p_r + CEIL_BIAS;
  assign lo_cell   = clamp_cell(p_r[vot_pkg::PROD_W-1:vot_pkg::FRAC_W]);
  assign hi_cell   = clamp_cell(p_ceil[vot_pkg::PROD_W-1:vot_pkg::FRAC_W]);
  assign cell_addr = AW'(AW'(x_r) * AW'(GRID_BITS) + AW'(y_r));

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    item_nxt      = item_r;
    d_nxt         = d_r;
    p_nxt         = p_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    mask_nxt      = mask_r;
    sweep_nxt     = sweep_r;
    clr_rep_nxt   = clr_rep_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_addr      = cell_addr;
    mem_wdata     = rd_data_r | mask_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_r;
        mem_wdata = '0;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == LAST_ADDR) begin
          sweep_nxt = '0;
          if (clr_rep_r) begin
            clr_rep_nxt = 1'b0;
            hit_nxt     = 1'b0;
            mask_nxt    = '0;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.req_type == vot_pkg::REQ_CLEAR) begin
            clr_rep_nxt = 1'b1;
            state_nxt   = S_CLEAR;
          end else begin
            ax_nxt    = AX_X;
            state_nxt = S_SUB;
          end
        end
      end
      S_SUB: begin
        d_nxt     = vot_pkg::DIFF_W'(pos_sel) - vot_pkg::DIFF_W'(org_sel);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        p_nxt     = d_r * $signed({1'b0, inv_sel});
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        case (ax_r)
          AX_X: begin
            x0_nxt    = lo_cell;
            x1_nxt    = hi_cell;
            ax_nxt    = AX_Y;
            state_nxt = S_SUB;
          end
          AX_Y: begin
            y0_nxt    = lo_cell;
            y1_nxt    = hi_cell;
            ax_nxt    = AX_Z;
            state_nxt = S_SUB;
          end
          default: begin
            mask_nxt  = (vot_pkg::WORD_W'(1) << lo_cell) |
                        (vot_pkg::WORD_W'(1) << hi_cell);
            x_nxt     = x0_r;
            y_nxt     = y0_r;
            hit_nxt   = 1'b0;
            state_nxt = S_RD;
          end
        endcase
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if ((rd_data_r & mask_r) != '0) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          mem_we = 1'b1;
          if (y_r != y1_r) begin
            y_nxt     = y_r + CW'(1);
            state_nxt = S_RD;
          end else if (x_r != x1_r) begin
            x_nxt     = x_r + CW'(1);
            y_nxt     = y0_r;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.occupied = hit_r;
          out_data_nxt.z_mask   = mask_r;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ax_r        <= AX_X;
      sweep_r     <= '0;
      clr_rep_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      sweep_r     <= sweep_nxt;
      clr_rep_r   <= clr_rep_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    d_r        <= d_nxt;
    p_r        <= p_nxt;
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    y0_r       <= y0_nxt;
    y1_r       <= y1_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    mask_r     <= mask_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/vot_chk.sv =====
// ----------------------------------------------------------------------------
// vot_chk
// Port-level checks of the voxel occupancy test-and-mark block.
// ----------------------------------------------------------------------------
module vot_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input vot_pkg::in_t                  in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input vot_pkg::out_t                 out_data,
  input logic                          cfg_we,
  input logic [vot_pkg::CFG_IDX_W-1:0] cfg_idx,
  input logic [vot_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_hit_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.occupied |-> out_data.z_mask != '0)
    else $error("occupied result without z bits");

  a_mask_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones(out_data.z_mask) <= 2)
    else $error("more than two z bits in result");

endmodule

bind voxel_occupancy_test_and_mark vot_chk u_vot_chk (.*);

// ===== test/voxel_occupancy_checker.sv =====
// ----------------------------------------------------------------------------
// voxel_occupancy_checker
// Watches the request, result and register ports of the voxel occupancy
// block. It keeps its own grid origin, scale and column bitmap, predicts
// the result of every accepted request and compares each result, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module voxel_occupancy_checker #(
  parameter int GRID = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  vot_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  vot_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [vot_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [vot_pkg::CFG_DAT_W-1:0] cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  logic signed [vot_pkg::POS_W-1:0] org_x, org_y, org_z;
  logic [vot_pkg::INV_W-1:0]        inv_x, inv_y, inv_z;
  logic [vot_pkg::WORD_W-1:0]       column [GRID*GRID];
  vot_pkg::out_t                    occupancy_due [$];

  function automatic int clamp_cell(longint c);
    if (c < 0) return 0;
    if (c > GRID - 1) return GRID - 1;
    return int'(c);
  endfunction

  function automatic void axis_span(input logic signed [vot_pkg::POS_W-1:0] pos, org,
                                    input logic [vot_pkg::INV_W-1:0] scale,
                                    output int lo, hi);
    longint scaled;
    scaled = (longint'(pos) - longint'(org)) * longint'(scale);
    lo = clamp_cell(scaled >>> vot_pkg::FRAC_W);
    hi = clamp_cell((scaled + (longint'(1) << vot_pkg::FRAC_W) - 1) >>> vot_pkg::FRAC_W);
  endfunction

  function automatic vot_pkg::out_t test_and_mark(vot_pkg::in_t req);
    vot_pkg::out_t res;
    int            x0, x1, y0, y1, z0, z1, col;
    res = '0;
    if (req.req_type == vot_pkg::REQ_CLEAR) begin
      foreach (column[i]) column[i] = '0;
      return res;
    end
    axis_span(req.pos_x, org_x, inv_x, x0, x1);
    axis_span(req.pos_y, org_y, inv_y, y0, y1);
    axis_span(req.pos_z, org_z, inv_z, z0, z1);
    res.z_mask = (vot_pkg::WORD_W'(1) << z0) | (vot_pkg::WORD_W'(1) << z1);
    for (int x = x0; x <= x1 && !res.occupied; x++) begin
      for (int y = y0; y <= y1 && !res.occupied; y++) begin
        col = x * GRID + y;
        if ((column[col] & res.z_mask) != '0) res.occupied = 1'b1;
        else column[col] |= res.z_mask;
      end
    end
    return res;
  endfunction

  function automatic void note_failure(string what, logic [vot_pkg::WORD_W-1:0] want_v,
                                       logic [vot_pkg::WORD_W-1:0] got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected %h, got %h", $time, what, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    vot_pkg::out_t want;
    vot_pkg::out_t got;
    if (!rst_n) begin
      org_x = '0;
      org_y = '0;
      org_z = '0;
      inv_x = vot_pkg::INV_CELL_RESET;
      inv_y = vot_pkg::INV_CELL_RESET;
      inv_z = vot_pkg::INV_CELL_RESET;
      foreach (column[i]) column[i] = '0;
      occupancy_due.delete();
      fail_count = 0;
      hit_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (occupancy_due.size() == 0) begin
          note_failure("result with no request waiting", '0, got.z_mask);
        end else begin
          want = occupancy_due.pop_front();
          if (got.occupied !== want.occupied) begin
            note_failure("occupied mismatch", vot_pkg::WORD_W'(want.occupied),
                         vot_pkg::WORD_W'(got.occupied));
          end
          if (got.z_mask !== want.z_mask) begin
            note_failure("z_mask mismatch", want.z_mask, got.z_mask);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = test_and_mark(in_data);
        if (want.occupied) hit_count++;
        occupancy_due.insert(occupancy_due.size(), want);
      end
      if (cfg_we) begin
        case (cfg_idx)
          vot_pkg::CFG_ORIGIN_X:   org_x = cfg_wdata;
          vot_pkg::CFG_ORIGIN_Y:   org_y = cfg_wdata;
          vot_pkg::CFG_ORIGIN_Z:   org_z = cfg_wdata;
          vot_pkg::CFG_INV_CELL_X: inv_x = cfg_wdata[vot_pkg::INV_W-1:0];
          vot_pkg::CFG_INV_CELL_Y: inv_y = cfg_wdata[vot_pkg::INV_W-1:0];
          vot_pkg::CFG_INV_CELL_Z: inv_z = cfg_wdata[vot_pkg::INV_W-1:0];
          default: ;
        endcase
      end
    end
    pending = occupancy_due.size();
  end

endmodule

// ===== test/tb_voxel_occupancy_test_and_mark.sv =====
// ----------------------------------------------------------------------------
// tb_voxel_occupancy_test_and_mark
// Drives points and map clears into the voxel occupancy block under a few
// directed grid settings (unit scale, extreme origins, zero and full scale),
// then random points aimed into the grid under random settings, with three
// mixes of sender and receiver idling and one long output stall. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_voxel_occupancy_test_and_mark;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     GRID             = 32;
  localparam int     POINTS_PER_PHASE = 100;
  localparam int     SETTLE_CYCLES    = 24;
  localparam int     STALL_CYCLES     = 400;
  localparam int     QUIET_LIMIT      = 20000;
  localparam longint UNIT_Q12         = 4096;
  localparam longint UNIT_Q8          = 256;
  localparam logic [vot_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [vot_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  vot_pkg::in_t                  in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  vot_pkg::out_t                 out_data;
  logic                          cfg_we = 1'b0;
  logic [vot_pkg::CFG_IDX_W-1:0] cfg_idx = vot_pkg::CFG_ORIGIN_X;
  logic [vot_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                          hold_req = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int fail_count, pending, hit_count;
  int point_count = 0;
  int clear_count = 0;
  int setting_count = 0;
  int spans [3] = '{4, 12, 32};

  logic signed [vot_pkg::POS_W-1:0] cur_org [3];
  logic [vot_pkg::INV_W-1:0]        cur_inv [3];

  voxel_occupancy_test_and_mark #(.GRID_BITS(GRID)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  voxel_occupancy_checker #(.GRID(GRID)) u_occupancy_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending),
    .hit_count (hit_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= STALL_CYCLES;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("voxel_occupancy_test_and_mark test failed");
      $finish;
    end
  end

  function automatic vot_pkg::in_t make_req(logic kind, logic [vot_pkg::POS_W-1:0] x, y, z);
    vot_pkg::in_t req;
    req.req_type = kind;
    req.pos_x = x;
    req.pos_y = y;
    req.pos_z = z;
    return req;
  endfunction

  // aim most points into the grid, a few anywhere in the field range
  function automatic logic signed [vot_pkg::POS_W-1:0] aim_axis(int axis, int span);
    longint cell_q8, offset, pos;
    if ($urandom_range(7) == 0) return vot_pkg::POS_W'($urandom);
    cell_q8 = longint'($urandom_range(span * 256 + 511)) - UNIT_Q8;
    if ($urandom_range(3) == 0) cell_q8 = cell_q8 & ~(UNIT_Q8 - 1);
    if (cur_inv[axis] == 0) offset = cell_q8;
    else offset = (cell_q8 * UNIT_Q12) / longint'(cur_inv[axis]);
    pos = longint'(cur_org[axis]) + offset;
    if (pos > 8388607) pos = 8388607;
    if (pos < -8388608) pos = -8388608;
    return vot_pkg::POS_W'(pos);
  endfunction

  task automatic load_grid(input logic signed [vot_pkg::POS_W-1:0] ox, oy, oz,
                           input logic [vot_pkg::INV_W-1:0] ix, iy, iz);
    logic [vot_pkg::CFG_IDX_W-1:0] idx_list [8];
    logic [vot_pkg::CFG_DAT_W-1:0] val_list [8];
    idx_list = '{CFG_SPARE_LO, vot_pkg::CFG_ORIGIN_X, vot_pkg::CFG_ORIGIN_Y,
                 vot_pkg::CFG_ORIGIN_Z, vot_pkg::CFG_INV_CELL_X,
                 vot_pkg::CFG_INV_CELL_Y, vot_pkg::CFG_INV_CELL_Z, CFG_SPARE_HI};
    val_list = '{vot_pkg::CFG_DAT_W'($urandom), ox, oy, oz,
                 {8'($urandom), ix}, {8'($urandom), iy}, {8'($urandom), iz},
                 vot_pkg::CFG_DAT_W'($urandom)};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx_list[i];
      cfg_wdata <= val_list[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_org = '{ox, oy, oz};
    cur_inv = '{ix, iy, iz};
    setting_count++;
  endtask

  task automatic load_random_grid();
    logic signed [vot_pkg::POS_W-1:0] org [3];
    logic [vot_pkg::INV_W-1:0]        scale [3];
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(3))
        0: org[a] = '0;
        1: org[a] = vot_pkg::POS_W'(int'($urandom_range(16383)) - 8192);
        default: org[a] = vot_pkg::POS_W'($urandom);
      endcase
      case ($urandom_range(7))
        0, 1: scale[a] = vot_pkg::INV_CELL_RESET;
        2, 3, 4: scale[a] = vot_pkg::INV_W'($urandom_range(8192, 1024));
        5, 6: scale[a] = vot_pkg::INV_W'($urandom);
        default: scale[a] = $urandom_range(1) ? '1 : '0;
      endcase
    end
    load_grid(org[0], org[1], org[2], scale[0], scale[1], scale[2]);
  endtask

  task automatic send_point(input vot_pkg::in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (req.req_type == vot_pkg::REQ_CLEAR) clear_count++;
    else point_count++;
  endtask

  task automatic run_random(int count, int span);
    vot_pkg::in_t req;
    for (int n = 0; n < count; n++) begin
      req.req_type = ($urandom_range(49) == 0) ? vot_pkg::REQ_CLEAR : vot_pkg::REQ_MARK;
      req.pos_x = aim_axis(0, span);
      req.pos_y = aim_axis(1, span);
      req.pos_z = aim_axis(2, span);
      send_point(req);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 26;
    recv_idle_pct <= 85;

    load_grid('0, '0, '0, vot_pkg::INV_CELL_RESET, vot_pkg::INV_CELL_RESET,
              vot_pkg::INV_CELL_RESET);
    send_point(make_req(vot_pkg::REQ_MARK, 24'h000000, 24'h000000, 24'h000000));
    send_point(make_req(vot_pkg::REQ_MARK, 24'h000000, 24'h000000, 24'h000000));
    send_point(make_req(vot_pkg::REQ_MARK, 24'h000180, 24'h000280, 24'h000380));
    send_point(make_req(vot_pkg::REQ_MARK, 24'h000200, 24'h000300, 24'h000400));
    send_point(make_req(vot_pkg::REQ_MARK, 24'h000500, 24'h000600, 24'h000700));
    send_point(make_req(vot_pkg::REQ_MARK, 24'h000480, 24'h000580, 24'h000700));
    send_point(make_req(vot_pkg::REQ_MARK, 24'h000400, 24'h000500, 24'h000700));
    send_point(make_req(vot_pkg::REQ_MARK, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    send_point(make_req(vot_pkg::REQ_MARK, 24'h800000, 24'h800000, 24'h800000));
    send_point(make_req(vot_pkg::REQ_MARK, 24'hFFFF80, 24'h001E80, 24'h001E80));
    send_point(make_req(vot_pkg::REQ_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_point(make_req(vot_pkg::REQ_MARK, 24'h000000, 24'h000000, 24'h000000));
    drain();

    load_grid(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, '1, '1, '1);
    send_point(make_req(vot_pkg::REQ_MARK, 24'h800000, 24'h800000, 24'h800000));
    send_point(make_req(vot_pkg::REQ_MARK, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    drain();

    load_grid(24'sh800000, 24'sh800000, 24'sh800000, '0, '1, 16'h0001);
    send_point(make_req(vot_pkg::REQ_MARK, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    send_point(make_req(vot_pkg::REQ_MARK, 24'h800000, 24'h800000, 24'h800000));
    send_point(make_req(vot_pkg::REQ_MARK, 24'h000000, 24'h000000, 24'h000000));
    drain();

    for (int mix = 0; mix < 3; mix++) begin
      send_idle_pct = (mix == 0) ? 26 : (mix == 1) ? 85 : 0;
      recv_idle_pct <= (mix == 0) ? 85 : (mix == 1) ? 26 : 0;
      for (int part = 0; part < 3; part++) begin
        load_random_grid();
        if (mix == 2 && part == 0) begin
          // stall the result side while requests keep coming
          hold_req <= 1'b1;
          @(posedge clk);
          hold_req <= 1'b0;
        end
        run_random(POINTS_PER_PHASE, spans[$urandom_range(2)]);
        drain();
      end
    end

    @(negedge clk);
    $display("Covered %0d points and %0d map clears under %0d grid settings.",
             point_count, clear_count, setting_count);
    $display("%0d points hit occupied voxels; three idling mixes and a %0d-cycle stall.",
             hit_count, STALL_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("voxel_occupancy_test_and_mark test passed");
    end else begin
      $display("voxel_occupancy_test_and_mark test failed");
    end
    $finish;
  end

endmodule

// ===== voxel_occupancy_test_and_mark.f =====
sv/vot_pkg.sv
sv/voxel_occupancy_test_and_mark.sv
sv/vot_chk.sv
test/voxel_occupancy_checker.sv
test/tb_voxel_occupancy_test_and_mark.sv
